FILE: rtl/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// shared types, constants and saturating helpers for the box collision resolver
// ----------------------------------------------------------------------------
package aabb_pkg;

   // coordinate width of the mover state, Q12.4 at 16 bits
   localparam int COORD_BITS = 16;
   // working width: holds any coordinate plus a 15 bit extent with headroom
   localparam int WIDE_BITS  = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // register indexes
   localparam logic [1:0] REG_MOVER_WIDTH  = 2'd0;
   localparam logic [1:0] REG_MOVER_HEIGHT = 2'd1;
   localparam logic [1:0] REG_FRAME_RIGHT  = 2'd2;

   localparam logic [14:0] MOVER_WIDTH_RST  = 15'd512;
   localparam logic [14:0] MOVER_HEIGHT_RST = 15'd768;
   localparam logic [14:0] FRAME_RIGHT_RST  = 15'd12800;

   // operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_BOX  = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [WIDE_BITS-1:0]  wide_type;
   typedef logic signed [15:0]           word16_type;

   localparam wide_type COORD_MAX_W = wide_type'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam wide_type COORD_MIN_W = -COORD_MAX_W - wide_type'(1);
   localparam wide_type S16_MAX_W   = wide_type'(32767);
   localparam wide_type S16_MIN_W   = wide_type'(-32768);

   typedef struct packed {
      logic [14:0] mover_width;
      logic [14:0] mover_height;
      logic [14:0] frame_right;
   } cfg_type;

   typedef struct packed {
      logic        operation;
      word16_type  pos_x;
      word16_type  pos_y;
      word16_type  prev_x;
      word16_type  prev_y;
      word16_type  vel_x;
      word16_type  vel_y;
      word16_type  box_left;
      word16_type  box_bottom;
      logic [14:0] box_width;
      logic [14:0] box_height;
      logic        last_box;
   } req_word_type;

   typedef struct packed {
      coord_type  cur_x;
      coord_type  cur_y;
      coord_type  old_x;
      coord_type  old_y;
      word16_type cur_vx;
      word16_type cur_vy;
      logic       grounded;
   } mover_state_type;

   function automatic wide_type coord_to_wide(coord_type c);
      return {{(WIDE_BITS - COORD_BITS){c[COORD_BITS-1]}}, c};
   endfunction

   function automatic wide_type s16_to_wide(logic [15:0] v);
      return {{(WIDE_BITS - 16){v[15]}}, v};
   endfunction

   function automatic wide_type u15_to_wide(logic [14:0] v);
      return {{(WIDE_BITS - 15){1'b0}}, v};
   endfunction

   function automatic coord_type sat_coord(wide_type v);
      coord_type r;
      if (v > COORD_MAX_W) begin
         r = COORD_MAX_W[COORD_BITS-1:0];
      end else if (v < COORD_MIN_W) begin
         r = COORD_MIN_W[COORD_BITS-1:0];
      end else begin
         r = v[COORD_BITS-1:0];
      end
      return r;
   endfunction

   function automatic word16_type pack16(coord_type c);
      wide_type   w;
      word16_type r;
      w = coord_to_wide(c);
      if (w > S16_MAX_W) begin
         r = S16_MAX_W[15:0];
      end else if (w < S16_MIN_W) begin
         r = S16_MIN_W[15:0];
      end else begin
         r = w[15:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/aabb_req_if.sv
// ----------------------------------------------------------------------------
// aabb_req_if
// request channel: mover loads and static box words with valid/ready
// ----------------------------------------------------------------------------
interface aabb_req_if;
   logic              valid;
   logic              ready;
   logic              operation;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic signed [15:0] prev_x;
   logic signed [15:0] prev_y;
   logic signed [15:0] vel_x;
   logic signed [15:0] vel_y;
   logic signed [15:0] box_left;
   logic signed [15:0] box_bottom;
   logic [14:0]       box_width;
   logic [14:0]       box_height;
   logic              last_box;

   modport source (
      output valid, operation, pos_x, pos_y, prev_x, prev_y, vel_x, vel_y,
             box_left, box_bottom, box_width, box_height, last_box,
      input  ready
   );

   modport sink (
      input  valid, operation, pos_x, pos_y, prev_x, prev_y, vel_x, vel_y,
             box_left, box_bottom, box_width, box_height, last_box,
      output ready
   );
endinterface

FILE: rtl/aabb_rsp_if.sv
// ----------------------------------------------------------------------------
// aabb_rsp_if
// response channel: resolved mover word with valid/ready
// ----------------------------------------------------------------------------
interface aabb_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] out_x;
   logic signed [15:0] out_y;
   logic signed [15:0] out_vel_x;
   logic signed [15:0] out_vel_y;
   logic              grounded;

   modport source (
      output valid, out_x, out_y, out_vel_x, out_vel_y, grounded,
      input  ready
   );

   modport sink (
      input  valid, out_x, out_y, out_vel_x, out_vel_y, grounded,
      output ready
   );
endinterface

FILE: rtl/aabb_collision_resolver.sv
// ----------------------------------------------------------------------------
// aabb_collision_resolver
// resolves one moving box against a run of static boxes; with no result held, one word per cycle
// ----------------------------------------------------------------------------
// usage:
//   req_chan words: operation 0 loads mover position, previous position and
//   velocity; operation 1 tests one static box and pushes the mover out along
//   the axis of least overlap. last_box ends a frame: x is clamped into the
//   window, one word goes out on rsp_chan. apb port sets mover width/height
//   and window width; user writes them only while the block is idle, unenforced.
// timing:
//   a request word waits in the input register while the step logic updates
//   the mover state; a last_box word's result is registered in the result
//   register. unless a held result stalls a last_box word, one word per cycle is
//   sustained, limited by each box's dependency on the state left by the last.
// reset:
//   synchronous active-high reset empties both registers, zeroes the mover
//   state and restores the register defaults (512, 768, 12800).
// stall:
//   a held result word stops the next last_box word and all words behind it;
//   earlier box words keep flowing into the state while the receiver stalls.
// ----------------------------------------------------------------------------
module aabb_collision_resolver (
   input  logic                               clock,
   input  logic                               reset,
   aabb_req_if.sink                           req_chan,
   aabb_rsp_if.source                         rsp_chan,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [aabb_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [aabb_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [aabb_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready
);
   import aabb_pkg::*;

   cfg_type         cfg;

   // input register
   logic            in_valid_ff;
   logic            in_valid_in;
   req_word_type    in_word_ff;
   req_word_type    req_word;

   // mover state
   mover_state_type state_ff;
   mover_state_type state_in;
   mover_state_type step_state;

   // result register
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            rsp_free;
   logic            step_go;
   logic            req_take;

   aabb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   aabb_resolve u_resolve (
      .cfg  (cfg),
      .cur  (state_ff),
      .word (in_word_ff),
      .nxt  (step_state)
   );

   // gather the request word
   always_comb begin
      req_word.operation  = req_chan.operation;
      req_word.pos_x      = req_chan.pos_x;
      req_word.pos_y      = req_chan.pos_y;
      req_word.prev_x     = req_chan.prev_x;
      req_word.prev_y     = req_chan.prev_y;
      req_word.vel_x      = req_chan.vel_x;
      req_word.vel_y      = req_chan.vel_y;
      req_word.box_left   = req_chan.box_left;
      req_word.box_bottom = req_chan.box_bottom;
      req_word.box_width  = req_chan.box_width;
      req_word.box_height = req_chan.box_height;
      req_word.last_box   = req_chan.last_box;
   end

   // result slot frees when empty or drained this cycle
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   // a non-final word always steps; a final one needs the result slot
   assign step_go  = in_valid_ff && (!in_word_ff.last_box || rsp_free);
   assign req_chan.ready = !in_valid_ff || step_go;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (step_go) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   assign state_in = step_go ? step_state : state_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (step_go && in_word_ff.last_box) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (step_go && in_word_ff.last_box) begin
         rsp_chan.out_x     <= pack16(step_state.cur_x);
         rsp_chan.out_y     <= pack16(step_state.cur_y);
         rsp_chan.out_vel_x <= step_state.cur_vx;
         rsp_chan.out_vel_y <= step_state.cur_vy;
         rsp_chan.grounded  <= step_state.grounded;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

endmodule

FILE: rtl/aabb_csr.sv
// ----------------------------------------------------------------------------
// aabb_csr
// apb register block: mover size and window width
// ----------------------------------------------------------------------------
module aabb_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [aabb_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [aabb_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [aabb_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                          pready,
   output aabb_pkg::cfg_type             cfg
);
   import aabb_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_MOVER_WIDTH:  cfg_in.mover_width  = pwdata[14:0];
            REG_MOVER_HEIGHT: cfg_in.mover_height = pwdata[14:0];
            REG_FRAME_RIGHT:  cfg_in.frame_right  = pwdata[14:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mover_width  <= MOVER_WIDTH_RST;
         cfg_ff.mover_height <= MOVER_HEIGHT_RST;
         cfg_ff.frame_right  <= FRAME_RIGHT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MOVER_WIDTH:  prdata = {{(CSR_DATA_BITS - 15){1'b0}}, cfg_ff.mover_width};
         REG_MOVER_HEIGHT: prdata = {{(CSR_DATA_BITS - 15){1'b0}}, cfg_ff.mover_height};
         REG_FRAME_RIGHT:  prdata = {{(CSR_DATA_BITS - 15){1'b0}}, cfg_ff.frame_right};
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/aabb_resolve.sv
// ----------------------------------------------------------------------------
// aabb_resolve
// one step of the mover state: load or box push-out, then on a last_box word the window clamp
// ----------------------------------------------------------------------------
module aabb_resolve (
   input  aabb_pkg::cfg_type         cfg,
   input  aabb_pkg::mover_state_type cur,
   input  aabb_pkg::req_word_type    word,
   output aabb_pkg::mover_state_type nxt
);
   import aabb_pkg::*;

   function automatic wide_type wmin(wide_type a, wide_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic wide_type wmax(wide_type a, wide_type b);
      return (a > b) ? a : b;
   endfunction

   always_comb begin
      mover_state_type st;
      wide_type mw, mh, ww;
      wide_type p_l, p_r, p_b, p_t;
      wide_type s_l, s_b, s_r, s_t;
      wide_type ov_x, ov_y, o_x, o_y, x_w;
      logic     hit, top, left;

      mw = u15_to_wide(cfg.mover_width);
      mh = u15_to_wide(cfg.mover_height);
      ww = u15_to_wide(cfg.frame_right);
      st = cur;

      p_l  = coord_to_wide(cur.cur_x);
      p_r  = coord_to_wide(sat_coord(p_l + mw));
      p_b  = coord_to_wide(cur.cur_y);
      p_t  = coord_to_wide(sat_coord(p_b + mh));
      s_l  = coord_to_wide(sat_coord(s16_to_wide(word.box_left)));
      s_b  = coord_to_wide(sat_coord(s16_to_wide(word.box_bottom)));
      s_r  = coord_to_wide(sat_coord(s_l + u15_to_wide(word.box_width)));
      s_t  = coord_to_wide(sat_coord(s_b + u15_to_wide(word.box_height)));
      o_x  = coord_to_wide(cur.old_x);
      o_y  = coord_to_wide(cur.old_y);
      hit  = (p_r > s_l) && (p_l < s_r) && (p_t > s_b) && (p_b < s_t);
      ov_x = wmin(p_r, s_r) - wmax(p_l, s_l);
      ov_y = wmin(p_t, s_t) - wmax(p_b, s_b);

      // side from previous position, velocity sign breaks the tie
      if (o_y >= s_t) begin
         top = 1'b1;
      end else if (coord_to_wide(sat_coord(o_y + mh)) <= s_b) begin
         top = 1'b0;
      end else begin
         top = cur.cur_vy[15];
      end

      if (coord_to_wide(sat_coord(o_x + mw)) <= s_l) begin
         left = 1'b1;
      end else if (o_x >= s_r) begin
         left = 1'b0;
      end else begin
         left = !cur.cur_vx[15] && (cur.cur_vx != '0);
      end

      if (word.operation == OP_LOAD) begin
         st.cur_x    = sat_coord(s16_to_wide(word.pos_x));
         st.cur_y    = sat_coord(s16_to_wide(word.pos_y));
         st.old_x    = sat_coord(s16_to_wide(word.prev_x));
         st.old_y    = sat_coord(s16_to_wide(word.prev_y));
         st.cur_vx   = word.vel_x;
         st.cur_vy   = word.vel_y;
         st.grounded = 1'b0;
      end else if (hit) begin
         if (ov_y < ov_x) begin
            if (top) begin
               st.cur_y    = s_t[COORD_BITS-1:0];
               st.grounded = 1'b1;
            end else begin
               st.cur_y = sat_coord(s_b - mh);
            end
            st.cur_vy = '0;
         end else begin
            st.cur_x  = left ? sat_coord(s_l - mw) : s_r[COORD_BITS-1:0];
            st.cur_vx = '0;
         end
      end

      // end of frame: left clamp first, then right clamp
      x_w = coord_to_wide(st.cur_x);
      if (word.last_box) begin
         if (x_w < wide_type'(0)) begin
            x_w = '0;
         end
         if (coord_to_wide(sat_coord(x_w + mw)) > coord_to_wide(sat_coord(ww))) begin
            x_w = coord_to_wide(sat_coord(ww - mw));
         end
         st.cur_x = x_w[COORD_BITS-1:0];
      end

      nxt = st;
   end

endmodule
